[rtl/lpbw_pkg.sv]
// Shared types and constants for the LED pixel buffer command writer.
// Used by lpbw_store and led_pixel_buffer_command_writer; depends on nothing.
`default_nettype none

package lpbw_pkg;

  // Number of pixel entries in the store.
  localparam int NUM_PIXELS = 256;

  // Address width of the store, kept at one bit at least.
  localparam int ADDR_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

  // One entry holds red, green and blue, red in the top byte.
  localparam int PIX_W = 24;

  // Store depth at the width of a 16-bit index plus carry.
  localparam logic [16:0] NUM_PIXELS_W = 17'(NUM_PIXELS);

  // Command codes.
  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_FILL     = 3'd1,
    CMD_SETPTR   = 3'd2,
    CMD_SEQWRITE = 3'd3,
    CMD_READ     = 3'd4
  } cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_e;

  // Write port of the pixel store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } mem_wr_t;

  // Read port of the pixel store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

`default_nettype wire

[rtl/lpbw_store.sv]
// Pixel store: one write port and one read port with registered read data.
// Depends on lpbw_pkg for its depth, widths and port structs.
`default_nettype none

module lpbw_store (
  input  wire logic                       clk_i,
  input  wire lpbw_pkg::mem_wr_t          wr_i,
  input  wire lpbw_pkg::mem_rd_t          rd_i,
  output logic [lpbw_pkg::PIX_W-1:0]      rdata_o
);

  logic [lpbw_pkg::PIX_W-1:0] mem_q [lpbw_pkg::NUM_PIXELS];
  logic [lpbw_pkg::PIX_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port, data registered and valid in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/led_pixel_buffer_command_writer.sv]
// Path to an offered result: set-pointer, sequential write and unknown commands go straight
// to DONE, read via READ, fill walks its clipped run, clear walks the whole store first.
// One item at a time; clear and fill walk the store one entry a cycle through its single
// write port. The next item is taken while a result waits in the output register.
// Reset: a clearing pass zeroes the store, no item taken during it; pointer zero.
`default_nettype none

module led_pixel_buffer_command_writer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [15:0] index_i,
  input  wire logic [15:0] count_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_red_o,
  output logic [7:0]       read_green_o,
  output logic [7:0]       read_blue_o,
  output logic             strip_reset_o
);

  localparam logic [lpbw_pkg::ADDR_W-1:0] LAST_ADDR =
    lpbw_pkg::ADDR_W'(lpbw_pkg::NUM_PIXELS - 1);

  lpbw_pkg::state_e state_q, state_d;

  logic [lpbw_pkg::ADDR_W-1:0] walk_addr_q, walk_addr_d;
  logic [lpbw_pkg::ADDR_W-1:0] walk_last_q, walk_last_d;
  logic [lpbw_pkg::PIX_W-1:0]  wdata_q, wdata_d;
  logic [15:0]                 seq_ptr_q, seq_ptr_d;
  logic                        rd_oor_q, rd_oor_d;
  logic [lpbw_pkg::PIX_W-1:0]  res_pix_q, res_pix_d;
  logic                        res_strip_q, res_strip_d;
  logic                        out_valid_q, out_valid_d;
  logic [lpbw_pkg::PIX_W-1:0]  out_pix_q, out_pix_d;
  logic                        out_strip_q, out_strip_d;

  lpbw_pkg::mem_wr_t           mem_wr;
  lpbw_pkg::mem_rd_t           mem_rd;
  logic [lpbw_pkg::PIX_W-1:0]  mem_rdata;

  logic                        in_accept;
  logic                        out_free;
  logic [16:0]                 fill_sum;
  logic [16:0]                 fill_stop;
  logic                        fill_any;
  logic [lpbw_pkg::ADDR_W-1:0] fill_last;
  logic                        index_in_range;
  logic                        ptr_in_range;

  // Handshake: items are taken only when the controller is idle.
  assign in_stall_o = (state_q != lpbw_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Fill run bounds, clipped at the end of the store.
  always_comb begin
    fill_sum       = {1'b0, index_i} + {1'b0, count_i};
    fill_stop      = (fill_sum > lpbw_pkg::NUM_PIXELS_W) ? lpbw_pkg::NUM_PIXELS_W : fill_sum;
    fill_any       = ({1'b0, index_i} < fill_stop);
    fill_last      = lpbw_pkg::ADDR_W'(fill_stop - 17'd1);
    index_in_range = ({1'b0, index_i} < lpbw_pkg::NUM_PIXELS_W);
    ptr_in_range   = ({1'b0, seq_ptr_q} < lpbw_pkg::NUM_PIXELS_W);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpbw_pkg::ST_INIT: begin
        if (walk_addr_q == LAST_ADDR) begin
          state_d = lpbw_pkg::ST_IDLE;
        end
      end
      lpbw_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (cmd_i)
            lpbw_pkg::CMD_CLEAR: state_d = lpbw_pkg::ST_WALK;
            lpbw_pkg::CMD_FILL:  state_d = fill_any ? lpbw_pkg::ST_WALK : lpbw_pkg::ST_DONE;
            lpbw_pkg::CMD_READ:  state_d = lpbw_pkg::ST_READ;
            default:             state_d = lpbw_pkg::ST_DONE;
          endcase
        end
      end
      lpbw_pkg::ST_WALK: begin
        if (walk_addr_q == walk_last_q) begin
          state_d = lpbw_pkg::ST_DONE;
        end
      end
      lpbw_pkg::ST_READ: state_d = lpbw_pkg::ST_DONE;
      lpbw_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lpbw_pkg::ST_IDLE;
        end
      end
      default: state_d = lpbw_pkg::ST_IDLE;
    endcase
  end

  // Store accesses and datapath updates.
  always_comb begin
    walk_addr_d = walk_addr_q;
    walk_last_d = walk_last_q;
    wdata_d     = wdata_q;
    seq_ptr_d   = seq_ptr_q;
    rd_oor_d    = rd_oor_q;
    res_pix_d   = res_pix_q;
    res_strip_d = res_strip_q;
    out_pix_d   = out_pix_q;
    out_strip_d = out_strip_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_wr      = '0;
    mem_rd      = '0;
    case (state_q)
      lpbw_pkg::ST_INIT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = walk_addr_q;
        mem_wr.data = '0;
        walk_addr_d = walk_addr_q + lpbw_pkg::ADDR_W'(1);
      end
      lpbw_pkg::ST_IDLE: begin
        if (in_accept) begin
          res_pix_d   = '0;
          res_strip_d = 1'b0;
          case (cmd_i)
            lpbw_pkg::CMD_CLEAR: begin
              walk_addr_d = '0;
              walk_last_d = LAST_ADDR;
              wdata_d     = '0;
              res_strip_d = 1'b1;
            end
            lpbw_pkg::CMD_FILL: begin
              walk_addr_d = index_i[lpbw_pkg::ADDR_W-1:0];
              walk_last_d = fill_last;
              wdata_d     = {red_i, green_i, blue_i};
            end
            lpbw_pkg::CMD_SETPTR: begin
              seq_ptr_d = index_i;
            end
            lpbw_pkg::CMD_SEQWRITE: begin
              if (ptr_in_range) begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = seq_ptr_q[lpbw_pkg::ADDR_W-1:0];
                mem_wr.data = {red_i, green_i, blue_i};
                seq_ptr_d   = seq_ptr_q + 16'd1;
              end
            end
            lpbw_pkg::CMD_READ: begin
              mem_rd.en   = 1'b1;
              mem_rd.addr = index_i[lpbw_pkg::ADDR_W-1:0];
              rd_oor_d    = !index_in_range;
            end
            default: begin
            end
          endcase
        end
      end
      lpbw_pkg::ST_WALK: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = walk_addr_q;
        mem_wr.data = wdata_q;
        walk_addr_d = walk_addr_q + lpbw_pkg::ADDR_W'(1);
      end
      lpbw_pkg::ST_READ: begin
        res_pix_d = rd_oor_q ? '0 : mem_rdata;
      end
      lpbw_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = res_pix_q;
          out_strip_d = res_strip_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpbw_pkg::ST_INIT;
      walk_addr_q <= '0;
      walk_last_q <= LAST_ADDR;
      wdata_q     <= '0;
      seq_ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_addr_q <= walk_addr_d;
      walk_last_q <= walk_last_d;
      wdata_q     <= wdata_d;
      seq_ptr_q   <= seq_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_oor_q    <= rd_oor_d;
    res_pix_q   <= res_pix_d;
    res_strip_q <= res_strip_d;
    out_pix_q   <= out_pix_d;
    out_strip_q <= out_strip_d;
  end

  // Pixel store.
  lpbw_store u_store (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign read_red_o    = out_pix_q[23:16];
  assign read_green_o  = out_pix_q[15:8];
  assign read_blue_o   = out_pix_q[7:0];
  assign strip_reset_o = out_strip_q;

`ifndef SYNTHESIS
  // A strip reset result never carries pixel data.
  a_strip_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && strip_reset_o) |-> (out_pix_q == '0))
    else $error("strip reset result with nonzero pixel");

  // The walk never passes its last address.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpbw_pkg::ST_WALK) |-> (walk_addr_q <= walk_last_q))
    else $error("walk address beyond last entry");

  // The clearing pass runs only once after reset.
  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lpbw_pkg::ST_INIT) |=> (state_q != lpbw_pkg::ST_INIT))
    else $error("clearing pass restarted");

  // The sequential pointer changes only when an item is taken.
  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o) |=> $stable(seq_ptr_q))
    else $error("sequential pointer changed without an item");
`endif

endmodule

`default_nettype wire
